### hdl/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// No dependencies; every other file of the block refers to it by scoped names.
package gha_pkg;

  localparam int SLOTS_DEF  = 1024;
  localparam int ROUNDS_DEF = 256;

  localparam int OP_W     = 2;
  localparam int TYPE_W   = 8;
  localparam int INDEX_W  = 20;
  localparam int HANDLE_W = 32;
  localparam int REQ_W    = 19;
  localparam int ID_W     = 18;
  localparam int STAT_W   = 2;
  localparam int USE_W    = 11;
  localparam int CFG_W    = 8;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ID   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FND  = 2'd3;

  // One row of the slot table.
  typedef struct packed {
    logic                valid;
    logic [ID_W-1:0]     id;
    logic [TYPE_W-1:0]   otype;
    logic [INDEX_W-1:0]  oindex;
    logic [HANDLE_W-1:0] handle;
  } slot_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic clear;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

### hdl/gha_req_if.sv
// Request channel of the handle allocator.
// Depends on gha_pkg for field widths.
interface gha_req_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::OP_W-1:0]      op;
  logic [gha_pkg::TYPE_W-1:0]    obj_type;
  logic [gha_pkg::INDEX_W-1:0]   obj_index;
  logic [gha_pkg::HANDLE_W-1:0]  obj_handle;
  logic signed [gha_pkg::REQ_W-1:0] req_id;

  modport source (output valid, op, obj_type, obj_index, obj_handle, req_id, input ready);
  modport sink   (input valid, op, obj_type, obj_index, obj_handle, req_id, output ready);
endinterface

### hdl/gha_rsp_if.sv
// Response channel of the handle allocator.
// Depends on gha_pkg for field widths.
interface gha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gha_pkg::STAT_W-1:0]   status;
  logic [gha_pkg::ID_W-1:0]     out_id;
  logic [gha_pkg::HANDLE_W-1:0] out_handle;
  logic [gha_pkg::TYPE_W-1:0]   out_type;
  logic [gha_pkg::INDEX_W-1:0]  out_index;
  logic [gha_pkg::USE_W-1:0]    in_use;

  modport source (output valid, status, out_id, out_handle, out_type, out_index, in_use,
                  input ready);
  modport sink   (input valid, status, out_id, out_handle, out_type, out_index, in_use,
                  output ready);
endinterface

### hdl/gha_cfg_if.sv
// Configuration write channel of the handle allocator (start round).
// Depends on gha_pkg for the data width.
interface gha_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [gha_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/gha_ctrl.sv
// Controller of the handle allocator: clearing pass, request sequencing, response valid.
// Depends on gha_pkg for the command and status structs.
module gha_ctrl #(
  parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gha_pkg::sts_t sts,
  output gha_pkg::cmd_t cmd
);

  // With a power of two slot count the slot is a mask and the quotient step is skipped.
  localparam bit DIRECT = (SLOTS & (SLOTS - 1)) == 0;

  typedef enum logic [1:0] {CLEAR, IDLE, QUOT, EXEC} state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.capture = accept;
    cmd.read    = (accept && DIRECT) || (state == QUOT);
    cmd.clear   = (state == CLEAR);
    cmd.commit  = (state == EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          if (sts.clear_last) state <= IDLE;
        end
        IDLE: begin
          if (accept) state <= DIRECT ? EXEC : QUOT;
        end
        QUOT: begin
          state <= EXEC;
        end
        EXEC: begin
          if (cmd.commit) state <= IDLE;
        end
        default: begin
          state <= CLEAR;
        end
      endcase
    end
  end

endmodule

### hdl/gha_dp.sv
// Datapath of the handle allocator: free FIFO, slot table, round bookkeeping, result register.
// Depends on gha_pkg for widths, codes and the slot row type.
module gha_dp #(
  parameter int SLOTS  = gha_pkg::SLOTS_DEF,
  parameter int ROUNDS = gha_pkg::ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gha_pkg::cmd_t                     cmd,
  output gha_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [gha_pkg::CFG_W-1:0]         cfg_data,
  input  logic [gha_pkg::OP_W-1:0]          op,
  input  logic [gha_pkg::TYPE_W-1:0]        obj_type,
  input  logic [gha_pkg::INDEX_W-1:0]       obj_index,
  input  logic [gha_pkg::HANDLE_W-1:0]      obj_handle,
  input  logic signed [gha_pkg::REQ_W-1:0]  req_id,
  output logic [gha_pkg::STAT_W-1:0]        status,
  output logic [gha_pkg::ID_W-1:0]          out_id,
  output logic [gha_pkg::HANDLE_W-1:0]      out_handle,
  output logic [gha_pkg::TYPE_W-1:0]        out_type,
  output logic [gha_pkg::INDEX_W-1:0]       out_index,
  output logic [gha_pkg::USE_W-1:0]         in_use
);

  localparam int ID_W     = gha_pkg::ID_W;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int ROUND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam bit DIRECT   = (SLOTS & (SLOTS - 1)) == 0;
  localparam int RECIP_W  = ID_W + 2;
  localparam longint RECIP = ((64'd1 << (ID_W + SLOT_W)) + SLOTS - 1) / SLOTS;
  localparam int PROD_W   = 2 * ID_W + SLOT_W + 2;
  localparam int EXT_W    = CNT_W + gha_pkg::USE_W;
  localparam int TBL_N    = 1 << gha_pkg::CFG_W;
  localparam logic [ROUND_W-1:0] ROUND_RST = ROUND_W'(1 % ROUNDS);

  // Start round modulo ROUNDS, a constant table.
  logic [ROUND_W-1:0] round_tbl [TBL_N];
  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    assign round_tbl[g] = ROUND_W'(g % ROUNDS);
  end

  // Memories.
  logic [SLOT_W-1:0]      fifo_mem [SLOTS];
  gha_pkg::slot_row_t     tbl_mem  [SLOTS];
  logic [SLOT_W-1:0]      fifo_q;
  gha_pkg::slot_row_t     row_q;

  // Captured request.
  logic [gha_pkg::OP_W-1:0]     op_r;
  logic [gha_pkg::TYPE_W-1:0]   type_r;
  logic [gha_pkg::INDEX_W-1:0]  index_r;
  logic [gha_pkg::HANDLE_W-1:0] handle_r;
  logic                         neg_r;
  logic [ID_W-1:0]              rid_r;
  logic [ID_W-1:0]              q_r;
  logic [SLOT_W-1:0]            slot_r;

  // Bookkeeping.
  logic [SLOT_W-1:0]  head, tail, clr_addr;
  logic [CNT_W-1:0]   fifo_count, fill, use_cnt, round_used, round_budget;
  logic [ROUND_W-1:0] round_now;

  // Slot of the incoming or captured ID.
  logic            neg_in;
  logic [ID_W-1:0] rid_in, rem;
  logic [PROD_W-1:0] prod;
  logic [SLOT_W-1:0] rd_slot;

  assign neg_in = req_id[gha_pkg::REQ_W-1];
  assign rid_in = neg_in ? '0 : req_id[ID_W-1:0];
  assign prod   = PROD_W'(rid_in) * PROD_W'(RECIP_W'(RECIP));
  assign rem    = rid_r - ID_W'(q_r * SLOTS);
  assign rd_slot = DIRECT ? rid_in[SLOT_W-1:0] : rem[SLOT_W-1:0];

  assign sts.clear_last = (clr_addr == SLOT_W'(SLOTS - 1));

  // Execute-step decode.
  logic               is_alloc, is_rel, is_look;
  logic               adv, fifo_empty, rel_ok, id_match;
  logic [ROUND_W-1:0] round_n;
  logic [CNT_W-1:0]   budget_n, used_n;
  logic [SLOT_W-1:0]  pop_slot;
  logic [ID_W-1:0]    new_id;
  logic [EXT_W-1:0]   use_ext;

  assign is_alloc   = (op_r == gha_pkg::OP_ALLOC);
  assign is_rel     = (op_r == gha_pkg::OP_RELEASE);
  assign is_look    = (op_r == gha_pkg::OP_LOOKUP);
  assign adv        = (round_used >= round_budget);
  assign budget_n   = adv ? (CNT_W'(SLOTS) - use_cnt) : round_budget;
  assign used_n     = (adv ? '0 : round_used) + CNT_W'(1);
  assign round_n    = !adv ? round_now :
                      (round_now == ROUND_W'(ROUNDS - 1)) ? '0 : round_now + ROUND_W'(1);
  assign fifo_empty = (fifo_count == '0);
  // FIFO positions never written since reset are read as their own index.
  assign pop_slot   = (CNT_W'(head) < fill) ? fifo_q : head;
  assign new_id     = ID_W'(pop_slot) + ID_W'(round_n * SLOTS);
  assign id_match   = row_q.valid && (row_q.id == rid_r);
  assign rel_ok     = !neg_r && id_match;

  logic alloc_do, rel_do;
  assign alloc_do = cmd.commit && is_alloc && !fifo_empty;
  assign rel_do   = cmd.commit && is_rel && rel_ok;

  // Slot table port.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      tbl_mem[clr_addr] <= '0;
    end else if (alloc_do) begin
      tbl_mem[pop_slot] <= '{valid: 1'b1, id: new_id, otype: type_r,
                             oindex: index_r, handle: handle_r};
    end else if (rel_do) begin
      tbl_mem[slot_r] <= '0;
    end
    if (cmd.read) begin
      row_q <= tbl_mem[rd_slot];
    end
  end

  // Free FIFO port.
  always_ff @(posedge clk) begin
    if (rel_do) begin
      fifo_mem[tail] <= slot_r;
    end
    if (cmd.read) begin
      fifo_q <= fifo_mem[head];
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op;
      type_r   <= obj_type;
      index_r  <= obj_index;
      handle_r <= obj_handle;
      neg_r    <= neg_in;
      rid_r    <= rid_in;
      q_r      <= prod[ID_W+SLOT_W +: ID_W];
    end
    if (cmd.read) begin
      slot_r <= rd_slot;
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      clr_addr     <= '0;
      fifo_count   <= CNT_W'(SLOTS);
      fill         <= '0;
      use_cnt      <= '0;
      round_used   <= '0;
      round_budget <= CNT_W'(SLOTS);
      round_now    <= ROUND_RST;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (cfg_we) begin
        round_now <= round_tbl[cfg_data];
      end
      if (cmd.commit && is_alloc) begin
        round_budget <= budget_n;
        round_used   <= used_n;
        round_now    <= round_n;
      end
      if (alloc_do) begin
        head       <= (head == SLOT_W'(SLOTS - 1)) ? '0 : head + SLOT_W'(1);
        fifo_count <= fifo_count - CNT_W'(1);
        use_cnt    <= use_cnt + CNT_W'(1);
      end
      if (rel_do) begin
        tail       <= (tail == SLOT_W'(SLOTS - 1)) ? '0 : tail + SLOT_W'(1);
        fifo_count <= fifo_count + CNT_W'(1);
        use_cnt    <= use_cnt - CNT_W'(1);
        if ((fill < CNT_W'(SLOTS)) && (CNT_W'(tail) == fill)) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  // Result register; in_use follows the counter after the step.
  logic [CNT_W-1:0] use_after;
  assign use_after = alloc_do ? use_cnt + CNT_W'(1) :
                     rel_do   ? use_cnt - CNT_W'(1) : use_cnt;
  assign use_ext   = EXT_W'(use_after);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= gha_pkg::ST_OK;
      out_id     <= '0;
      out_handle <= '0;
      out_type   <= '0;
      out_index  <= '0;
      in_use     <= use_ext[gha_pkg::USE_W-1:0];
      if (is_alloc) begin
        if (fifo_empty) begin
          status <= gha_pkg::ST_NO_SLOT;
        end else begin
          out_id <= new_id;
        end
      end else if (is_rel) begin
        out_id <= rid_r;
        if (!rel_ok) status <= gha_pkg::ST_BAD_ID;
      end else if (is_look) begin
        if (neg_r) begin
          status <= gha_pkg::ST_BAD_ID;
        end else begin
          out_id <= rid_r;
          if (slot_r == '0 || !row_q.valid) begin
            status <= gha_pkg::ST_NOT_FND;
          end else if (row_q.id != rid_r) begin
            status <= gha_pkg::ST_BAD_ID;
          end else begin
            out_handle <= row_q.handle;
            out_type   <= row_q.otype;
            out_index  <= row_q.oindex;
          end
        end
      end
    end
  end

endmodule

### hdl/generational_handle_allocator_unit.sv
// Top level of the generational handle allocator: controller plus datapath.
// Depends on gha_pkg, the three channel interfaces, gha_ctrl and gha_dp.
//
//  channel | role   | word
//  --------+--------+----------------------------------------------------
//  req     | sink   | op, obj_type, obj_index, obj_handle, req_id
//  rsp     | source | status, out_id, out_handle, out_type, out_index, in_use
//  cfg     | sink   | data: start round, taken modulo ROUNDS into the round
//
// A request is captured at acceptance; when SLOTS is a power of two the slot
// table and free FIFO memories are read then too, otherwise the slot quotient
// multiply is registered at capture and they are read in a separate quotient
// step. An update step then writes both and loads the response register. After
// reset a clearing pass invalidates the slot table; no request is taken during
// it, configuration writes are. A new request is accepted while the previous
// response waits; the update step holds until the response register is free.
module generational_handle_allocator_unit #(
  parameter int SLOTS  = gha_pkg::SLOTS_DEF,
  parameter int ROUNDS = gha_pkg::ROUNDS_DEF
) (
  input logic       clk,
  input logic       rst,
  gha_req_if.sink   req,
  gha_rsp_if.source rsp,
  gha_cfg_if.sink   cfg
);

  gha_pkg::cmd_t cmd;
  gha_pkg::sts_t sts;
  logic          cfg_we;

  // The start round channel is always ready; a write in the cycle of an allocate commit is lost.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  gha_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gha_dp #(.SLOTS(SLOTS), .ROUNDS(ROUNDS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg.data),
    .op        (req.op),
    .obj_type  (req.obj_type),
    .obj_index (req.obj_index),
    .obj_handle(req.obj_handle),
    .req_id    (req.req_id),
    .status    (rsp.status),
    .out_id    (rsp.out_id),
    .out_handle(rsp.out_handle),
    .out_type  (rsp.out_type),
    .out_index (rsp.out_index),
    .in_use    (rsp.in_use)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for generational_handle_allocator_unit: allocate, release and lookup
// words against an in-bench model of the slot table, free FIFO and round counter.
// Depends on gha_pkg, the three channel interfaces and the RTL of the block.
module tb_top;
  import gha_pkg::*;

  localparam int NSLOT = 1024;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [TYPE_W-1:0]     otype;
    logic [INDEX_W-1:0]    oindex;
    logic [HANDLE_W-1:0]   handle;
    logic [REQ_W-1:0]      rid;
  } req_word_t;

  typedef struct {
    logic [STAT_W-1:0]     status;
    logic [ID_W-1:0]       id;
    logic [HANDLE_W-1:0]   handle;
    logic [TYPE_W-1:0]     otype;
    logic [INDEX_W-1:0]    oindex;
    logic [USE_W-1:0]      in_use;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gha_req_if req_ch();
  gha_rsp_if rsp_ch();
  gha_cfg_if cfg_ch();

  generational_handle_allocator_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #4 clk = ~clk;

  // Stimulus waiting for the driver, and the responses the model predicts.
  req_word_t pending_words[$];
  rsp_word_t predicted_rsp[$];
  int        err_cnt = 0;
  int        snd_idle = 19;
  int        rcv_idle = 52;

  // Model of the allocator state.
  logic [9:0]          free_slots[NSLOT];
  logic [9:0]          fifo_rd;
  logic [9:0]          fifo_wr;
  logic [USE_W-1:0]    fifo_fill;
  logic                tbl_valid[NSLOT];
  logic [ID_W-1:0]     tbl_id[NSLOT];
  logic [TYPE_W-1:0]   tbl_type[NSLOT];
  logic [INDEX_W-1:0]  tbl_index[NSLOT];
  logic [HANDLE_W-1:0] tbl_handle[NSLOT];
  logic [7:0]          cur_round;
  logic [USE_W-1:0]    round_spent;
  logic [USE_W-1:0]    round_quota;
  logic [USE_W-1:0]    live_count;
  // IDs currently handed out, so that the generator can release and look them up.
  logic [ID_W-1:0]     live_ids[$];

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      free_slots[i] = i[9:0];
      tbl_valid[i] = 1'b0;
    end
    fifo_rd = '0;
    fifo_wr = '0;
    fifo_fill = USE_W'(NSLOT);
    cur_round = 8'd1;
    round_spent = '0;
    round_quota = USE_W'(NSLOT);
    live_count = '0;
  end

  // Applies one accepted request word to the model and returns the response it should give.
  function automatic rsp_word_t allocator_step(req_word_t w);
    rsp_word_t  r;
    logic       neg;
    logic [17:0] rid;
    logic [9:0] slot;
    logic [9:0] s;
    neg = w.rid[REQ_W-1];
    rid = neg ? '0 : w.rid[ID_W-1:0];
    slot = rid[9:0];
    r.status = ST_OK;
    r.id = '0;
    r.handle = '0;
    r.otype = '0;
    r.oindex = '0;
    case (w.op)
      OP_ALLOC: begin
        // The round moves on before the FIFO is even looked at.
        if (round_spent >= round_quota) begin
          round_quota = USE_W'(NSLOT) - live_count;
          round_spent = '0;
          cur_round = cur_round + 8'd1;
        end
        round_spent = round_spent + 1'b1;
        if (fifo_fill == 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          s = free_slots[fifo_rd];
          fifo_rd = fifo_rd + 1'b1;
          fifo_fill = fifo_fill - 1'b1;
          tbl_valid[s] = 1'b1;
          tbl_id[s] = {cur_round, s};
          tbl_type[s] = w.otype;
          tbl_index[s] = w.oindex;
          tbl_handle[s] = w.handle;
          live_count = live_count + 1'b1;
          live_ids.push_back({cur_round, s});
          r.id = {cur_round, s};
        end
      end
      OP_RELEASE: begin
        r.id = rid;
        if (neg || !tbl_valid[slot] || tbl_id[slot] != rid) begin
          r.status = ST_BAD_ID;
        end else begin
          free_slots[fifo_wr] = slot;
          fifo_wr = fifo_wr + 1'b1;
          fifo_fill = fifo_fill + 1'b1;
          tbl_valid[slot] = 1'b0;
          live_count = live_count - 1'b1;
          for (int i = 0; i < live_ids.size(); i++) begin
            if (live_ids[i] == rid) begin
              live_ids.delete(i);
              break;
            end
          end
        end
      end
      OP_LOOKUP: begin
        if (neg) begin
          r.status = ST_BAD_ID;
        end else begin
          r.id = rid;
          // Slot 0 is never reported as found, even while it is allocated.
          if (slot == 0 || !tbl_valid[slot]) begin
            r.status = ST_NOT_FND;
          end else if (tbl_id[slot] != rid) begin
            r.status = ST_BAD_ID;
          end else begin
            r.handle = tbl_handle[slot];
            r.otype = tbl_type[slot];
            r.oindex = tbl_index[slot];
          end
        end
      end
      default: begin
        // The unused op code leaves everything as it was.
      end
    endcase
    r.in_use = live_count;
    return r;
  endfunction

  // Request driver: on acceptance the word goes through the model; the channel is then
  // refilled from the pending queue unless the sender chooses to idle this cycle.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.op <= '0;
      req_ch.obj_type <= '0;
      req_ch.obj_index <= '0;
      req_ch.obj_handle <= '0;
      req_ch.req_id <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted_rsp.push_back(allocator_step('{req_ch.op, req_ch.obj_type,
            req_ch.obj_index, req_ch.obj_handle, req_ch.req_id}));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= snd_idle) begin
          req_word_t w;
          w = pending_words.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.op <= w.op;
          req_ch.obj_type <= w.otype;
          req_ch.obj_index <= w.oindex;
          req_ch.obj_handle <= w.handle;
          req_ch.req_id <= w.rid;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: every accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_rsp.size() == 0) begin
          $error("response word with no prediction waiting: status %0d id %0h",
                 rsp_ch.status, rsp_ch.out_id);
          err_cnt++;
        end else begin
          rsp_word_t e;
          e = predicted_rsp.pop_front();
          if (rsp_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
            err_cnt++;
          end
          if (rsp_ch.out_id !== e.id) begin
            $error("out_id: expected %0h, got %0h", e.id, rsp_ch.out_id);
            err_cnt++;
          end
          if (rsp_ch.out_handle !== e.handle) begin
            $error("out_handle: expected %0h, got %0h", e.handle, rsp_ch.out_handle);
            err_cnt++;
          end
          if (rsp_ch.out_type !== e.otype) begin
            $error("out_type: expected %0h, got %0h", e.otype, rsp_ch.out_type);
            err_cnt++;
          end
          if (rsp_ch.out_index !== e.oindex) begin
            $error("out_index: expected %0h, got %0h", e.oindex, rsp_ch.out_index);
            err_cnt++;
          end
          if (rsp_ch.in_use !== e.in_use) begin
            $error("in_use: expected %0d, got %0d", e.in_use, rsp_ch.in_use);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: the clearing pass after reset and the longest stalls stay far below the limit.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_word(logic [OP_W-1:0] op, logic [TYPE_W-1:0] t, logic [INDEX_W-1:0] i,
                          logic [HANDLE_W-1:0] h, logic [REQ_W-1:0] r);
    pending_words.push_back('{op, t, i, h, r});
  endtask

  // Blocks until every word has been answered, then lets the pipeline settle.
  task automatic wait_drained();
    while (pending_words.size() > 0 || req_ch.valid || predicted_rsp.size() > 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes the start round without waiting for the block to be idle; the model takes it at the handshake.
  task automatic write_start_round(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_round = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // Picks an ID for release or lookup: mostly a live one, sometimes a stale round of a
  // live one, sometimes anything the 19-bit field allows.
  function automatic logic [REQ_W-1:0] pick_id();
    logic [ID_W-1:0] id;
    int k;
    k = $urandom_range(99);
    if (live_ids.size() > 0 && k < 80) begin
      return {1'b0, live_ids[$urandom_range(live_ids.size() - 1)]};
    end else if (live_ids.size() > 0 && k < 90) begin
      id = live_ids[$urandom_range(live_ids.size() - 1)];
      id[17:10] = id[17:10] + 8'($urandom_range(1, 255));
      return {1'b0, id};
    end
    return REQ_W'($urandom_range(19'h7FFFF));
  endfunction

  // One random word. Weights are allocate / release / lookup out of 100, the rest is op 3.
  task automatic random_word(int w_alloc, int w_rel, int w_look);
    int k;
    logic [OP_W-1:0] op;
    // Keep at most two words queued for the driver so that picked IDs track the table.
    while (pending_words.size() > 1) @(negedge clk);
    k = $urandom_range(99);
    if (k < w_alloc) op = OP_ALLOC;
    else if (k < w_alloc + w_rel) op = OP_RELEASE;
    else if (k < w_alloc + w_rel + w_look) op = OP_LOOKUP;
    else op = 2'd3;
    add_word(op, TYPE_W'($urandom_range(8'hFF)), INDEX_W'($urandom_range(20'hFFFFF)),
             $urandom(), pick_id());
  endtask

  initial begin
    bit filling;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Phase one: top round, directed corner cases, then a mixed random load.
    write_start_round(8'd255);
    add_word(OP_ALLOC, 8'hFF, 20'hFFFFF, 32'hFFFF_FFFF, '0);   // slot 0
    add_word(OP_ALLOC, 8'h00, 20'h00000, 32'h0, 19'h7FFFF);    // slot 1
    add_word(OP_LOOKUP, '0, '0, '0, 19'h3FC01);                // found
    add_word(OP_LOOKUP, '0, '0, '0, 19'h3FC00);                // slot zero is never found
    add_word(OP_LOOKUP, '0, '0, '0, 19'h7FFFF);                // negative ID
    add_word(OP_RELEASE, '0, '0, '0, 19'h7FFFF);               // negative ID
    add_word(OP_RELEASE, '0, '0, '0, 19'h3FC02);               // slot never allocated
    add_word(OP_LOOKUP, '0, '0, '0, 19'h3FC02);                // not found
    add_word(OP_LOOKUP, '0, '0, '0, 19'h00001);                // valid slot, wrong round
    add_word(OP_RELEASE, '0, '0, '0, 19'h00001);               // valid slot, wrong round
    add_word(2'd3, 8'h5A, 20'h12345, 32'hDEAD_BEEF, 19'h3FC01); // ignored op
    add_word(OP_LOOKUP, '0, '0, '0, 19'h3FFFF);                // highest ID, free slot
    add_word(OP_RELEASE, '0, '0, '0, 19'h3FC01);
    add_word(OP_LOOKUP, '0, '0, '0, 19'h3FC01);                // gone after release
    add_word(OP_RELEASE, '0, '0, '0, 19'h3FC00);
    add_word(OP_ALLOC, 8'hAA, 20'h55555, 32'hA5A5_A5A5, 19'h40000);
    add_word(OP_LOOKUP, '0, '0, '0, 19'h3FC02);                // slot 2 found
    repeat (500) random_word(40, 30, 25);
    wait_drained();

    // Phase two: round zero, the idle pattern reversed; fill the table until allocations
    // fail and the round moves on, then drain it again.
    snd_idle = 52;
    rcv_idle = 19;
    write_start_round(8'd0);
    filling = 1'b1;
    for (int n = 0; n < 1100; n++) begin
      if (filling && live_count == NSLOT && $urandom_range(15) == 0) filling = 1'b0;
      else if (!filling && live_count < 300) filling = 1'b1;
      if (filling) random_word(95, 0, 5);
      else random_word(10, 70, 20);
    end
    wait_drained();

    // Phase three: a random start round, no idling on either side.
    snd_idle = 0;
    rcv_idle = 0;
    write_start_round(CFG_W'($urandom_range(8'hFF)));
    repeat (400) random_word(35, 35, 25);
    wait_drained();
    repeat (20) @(negedge clk);

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
